### rtl/core/lnws_pkg.sv
// Shared types, constants and the microcode program of the LCD nibble write sequencer.
package lnws_pkg;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_CMD  = 2'd1,
    OP_CHAR = 2'd2,
    OP_POS  = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PULSE  = 2'd0;
  localparam logic [1:0] CFG_SETUP  = 2'd1;
  localparam logic [1:0] CFG_SETTLE = 2'd2;

  localparam logic [7:0]  PULSE_RST  = 8'd1;
  localparam logic [9:0]  SETUP_RST  = 10'd50;
  localparam logic [11:0] SETTLE_RST = 12'd675;

  // Fixed power-up waits in microseconds.
  localparam logic [13:0] INIT_WAIT_US   = 14'd15000;
  localparam logic [13:0] SECOND_WAIT_US = 14'd5000;
  localparam logic [13:0] SHORT_WAIT_US  = 14'd200;

  localparam logic [7:0] POS_BASE = 8'h80;

  // Microcode addresses.
  localparam logic [3:0] UA_INIT = 4'd0;
  localparam logic [3:0] UA_BYTE = 4'd11;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0]  pulse;
    logic [9:0]  setup;
    logic [11:0] settle;
  } cfg_t;

  // Data nibble source.
  typedef enum logic [2:0] {
    NIB_ZERO,
    NIB_THREE,
    NIB_TWO,
    NIB_HI,
    NIB_LO
  } nib_sel_e;

  // Hold time source.
  typedef enum logic [2:0] {
    HOLD_INIT,
    HOLD_SECOND,
    HOLD_SHORT,
    HOLD_PULSE,
    HOLD_SETUP_PULSE,
    HOLD_SETTLE
  } hold_sel_e;

  // Sequencing: fall through, or end of byte with a jump back while bytes remain.
  typedef enum logic {
    BR_NEXT,
    BR_BYTE_LOOP
  } br_e;

  // One control word.
  typedef struct packed {
    logic      en;
    nib_sel_e  nib;
    hold_sel_e hold;
    br_e       br;
    logic [3:0] target;
  } uword_t;

  // Control from the sequencer to the segment datapath.
  typedef struct packed {
    logic       load;
    logic       adv;
    uword_t     uw;
    logic [1:0] idx;
    logic       init;
    logic       last;
  } dp_ctrl_t;

  function automatic uword_t uw_mk(logic en, nib_sel_e nib, hold_sel_e hold, br_e br);
    uword_t w;
    w.en     = en;
    w.nib    = nib;
    w.hold   = hold;
    w.br     = br;
    w.target = UA_BYTE;
    return w;
  endfunction

  // The program: power-up nibbles, then the shared five-step byte transfer.
  function automatic uword_t ucode_rom(logic [3:0] addr);
    uword_t w;
    unique case (addr)
      4'd0:    w = uw_mk(1'b0, NIB_ZERO,  HOLD_INIT,        BR_NEXT);
      4'd1:    w = uw_mk(1'b0, NIB_THREE, HOLD_PULSE,       BR_NEXT);
      4'd2:    w = uw_mk(1'b1, NIB_THREE, HOLD_PULSE,       BR_NEXT);
      4'd3:    w = uw_mk(1'b0, NIB_THREE, HOLD_SECOND,      BR_NEXT);
      4'd4:    w = uw_mk(1'b1, NIB_THREE, HOLD_PULSE,       BR_NEXT);
      4'd5:    w = uw_mk(1'b0, NIB_THREE, HOLD_SHORT,       BR_NEXT);
      4'd6:    w = uw_mk(1'b1, NIB_THREE, HOLD_PULSE,       BR_NEXT);
      4'd7:    w = uw_mk(1'b0, NIB_THREE, HOLD_SHORT,       BR_NEXT);
      4'd8:    w = uw_mk(1'b0, NIB_TWO,   HOLD_PULSE,       BR_NEXT);
      4'd9:    w = uw_mk(1'b1, NIB_TWO,   HOLD_PULSE,       BR_NEXT);
      4'd10:   w = uw_mk(1'b0, NIB_TWO,   HOLD_PULSE,       BR_NEXT);
      4'd11:   w = uw_mk(1'b0, NIB_HI,    HOLD_SETUP_PULSE, BR_NEXT);
      4'd12:   w = uw_mk(1'b1, NIB_HI,    HOLD_PULSE,       BR_NEXT);
      4'd13:   w = uw_mk(1'b0, NIB_LO,    HOLD_PULSE,       BR_NEXT);
      4'd14:   w = uw_mk(1'b1, NIB_LO,    HOLD_PULSE,       BR_NEXT);
      default: w = uw_mk(1'b0, NIB_LO,    HOLD_SETTLE,      BR_BYTE_LOOP);
    endcase
    return w;
  endfunction

  // Command bytes sent after the power-up nibbles.
  function automatic logic [7:0] init_cmd(logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h28;
      2'd1:    b = 8'h0F;
      2'd2:    b = 8'h01;
      default: b = 8'h06;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/lnws_intf.sv
// Channel interfaces: requests, pin segments and configuration writes.

// Request channel.
interface lnws_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] value;
  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// Pin segment channel.
interface lnws_seg_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic        read_write;
  logic        enable;
  logic [3:0]  nibble;
  logic [13:0] hold_us;
  logic        last;
  modport source (output valid, output reg_select, output read_write, output enable,
                  output nibble, output hold_us, output last, input ready);
  modport sink   (input valid, input reg_select, input read_write, input enable,
                  input nibble, input hold_us, input last, output ready);
endinterface

// Configuration write channel.
interface lnws_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/lnws_cfg_regs.sv
// Configuration register file: pulse, setup and settle times.
module lnws_cfg_regs import lnws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_valid_i,
  output logic        wr_ready_o,
  input  logic [1:0]  wr_index_i,
  input  logic [11:0] wr_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;

  // Decode the write; an index beyond the list leaves everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_index_i)
        CFG_PULSE:  cfg_d.pulse  = wr_data_i[7:0];
        CFG_SETUP:  cfg_d.setup  = wr_data_i[9:0];
        CFG_SETTLE: cfg_d.settle = wr_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse  <= PULSE_RST;
      cfg_q.setup  <= SETUP_RST;
      cfg_q.settle <= SETTLE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/lnws_useq.sv
// Microcode sequencer: step counter, program fetch, byte loop and handshakes.
module lnws_useq import lnws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  logic [1:0] req_op_i,
  output logic       seg_valid_o,
  input  logic       seg_ready_i,
  output dp_ctrl_t   ctrl_o
);

  logic       busy_q, busy_d;
  logic [3:0] pc_q, pc_d;
  logic [1:0] idx_q, idx_d;
  logic       init_q, init_d;
  logic       vld_q, vld_d;
  logic       load, adv, more;
  uword_t     uw;

  // Fetch the current control word.
  assign uw = ucode_rom(pc_q);

  // A new request is taken only while no program runs.
  assign req_ready_o = !busy_q;
  assign load        = req_valid_i && !busy_q;
  assign adv         = busy_q && (!vld_q || seg_ready_i);

  // More command bytes remain only in the initialisation program.
  assign more = init_q && (idx_q != 2'd3);

  // Next step, byte index and output valid.
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    idx_d  = idx_q;
    init_d = init_q;
    vld_d  = vld_q;
    if (seg_ready_i) begin
      vld_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      init_d = (req_op_i == OP_INIT);
      pc_d   = (req_op_i == OP_INIT) ? UA_INIT : UA_BYTE;
      idx_d  = 2'd0;
    end else if (adv) begin
      vld_d = 1'b1;
      unique case (uw.br)
        BR_NEXT: begin
          pc_d = pc_q + 4'd1;
        end
        BR_BYTE_LOOP: begin
          if (more) begin
            pc_d  = uw.target;
            idx_d = idx_q + 2'd1;
          end else begin
            busy_d = 1'b0;
          end
        end
        default: pc_d = pc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= UA_INIT;
      idx_q  <= 2'd0;
      init_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      idx_q  <= idx_d;
      init_q <= init_d;
      vld_q  <= vld_d;
    end
  end

  // Control to the datapath.
  always_comb begin
    ctrl_o.load = load;
    ctrl_o.adv  = adv;
    ctrl_o.uw   = uw;
    ctrl_o.idx  = idx_q;
    ctrl_o.init = init_q;
    ctrl_o.last = (uw.br == BR_BYTE_LOOP) && !more;
  end

  assign seg_valid_o = vld_q;

endmodule

### rtl/core/lnws_seg_dp.sv
// Segment datapath: request byte, nibble and hold selection, output register.
module lnws_seg_dp import lnws_pkg::*; (
  input  logic        clk_i,
  input  dp_ctrl_t    ctrl_i,
  input  cfg_t        cfg_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  value_i,
  output logic        reg_select_o,
  output logic        enable_o,
  output logic [3:0]  nibble_o,
  output logic [13:0] hold_us_o,
  output logic        last_o
);

  logic [7:0]  byte_q, byte_d;
  logic        rs_q, rs_d;
  logic [7:0]  byte_cur;
  logic [3:0]  nib_d;
  logic [13:0] hold_d;
  logic        en_q, last_q, rso_q;
  logic [3:0]  nib_q;
  logic [13:0] hold_q;

  // Byte and register select of an incoming request.
  always_comb begin
    rs_d = (op_i == OP_CHAR);
    unique case (op_i)
      OP_POS:  byte_d = 8'(POS_BASE + value_i);
      default: byte_d = value_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      byte_q <= byte_d;
      rs_q   <= rs_d;
    end
  end

  // Byte in flight: a fixed command during initialisation, else the request byte.
  assign byte_cur = ctrl_i.init ? init_cmd(ctrl_i.idx) : byte_q;

  // Data nibble of this step.
  always_comb begin
    unique case (ctrl_i.uw.nib)
      NIB_ZERO:  nib_d = 4'h0;
      NIB_THREE: nib_d = 4'h3;
      NIB_TWO:   nib_d = 4'h2;
      NIB_HI:    nib_d = byte_cur[7:4];
      NIB_LO:    nib_d = byte_cur[3:0];
      default:   nib_d = 4'h0;
    endcase
  end

  // Hold time of this step.
  always_comb begin
    unique case (ctrl_i.uw.hold)
      HOLD_INIT:        hold_d = INIT_WAIT_US;
      HOLD_SECOND:      hold_d = SECOND_WAIT_US;
      HOLD_SHORT:       hold_d = SHORT_WAIT_US;
      HOLD_PULSE:       hold_d = 14'(cfg_i.pulse);
      HOLD_SETUP_PULSE: hold_d = 14'(cfg_i.setup) + 14'(cfg_i.pulse);
      HOLD_SETTLE:      hold_d = 14'(cfg_i.settle);
      default:          hold_d = '0;
    endcase
  end

  // Output register, loaded on every step.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      rso_q  <= ctrl_i.init ? 1'b0 : rs_q;
      en_q   <= ctrl_i.uw.en;
      nib_q  <= nib_d;
      hold_q <= hold_d;
      last_q <= ctrl_i.last;
    end
  end

  assign reg_select_o = rso_q;
  assign enable_o     = en_q;
  assign nibble_o     = nib_q;
  assign hold_us_o    = hold_q;
  assign last_o       = last_q;

endmodule

### rtl/core/lcd_nibble_write_sequencer_core.sv
// Top level of the LCD nibble write sequencer: registers, sequencer and datapath.
// After the request transaction the busy flag is set, and then the output register loads the first segment.
// Throughput: one segment per cycle while the sink is ready, one control word per step;
// a byte request takes 5 segments, and the next request is taken once its last step has advanced.
// An initialise request takes 31 segments.
// Reset: pulse_us 1, setup_us 50, settle_us 675, sequencer idle, no segment pending.
module lcd_nibble_write_sequencer_core import lnws_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lnws_req_if.sink   req_i,
  lnws_seg_if.source seg_o,
  lnws_cfg_if.sink   cfg_i
);

  cfg_t     cfg;
  dp_ctrl_t ctrl;

  // Configuration registers.
  lnws_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // Microcode sequencer.
  lnws_useq u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_op_i    (req_i.op),
    .seg_valid_o (seg_o.valid),
    .seg_ready_i (seg_o.ready),
    .ctrl_o      (ctrl)
  );

  // Segment datapath.
  lnws_seg_dp u_dp (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .cfg_i        (cfg),
    .op_i         (req_i.op),
    .value_i      (req_i.value),
    .reg_select_o (seg_o.reg_select),
    .enable_o     (seg_o.enable),
    .nibble_o     (seg_o.nibble),
    .hold_us_o    (seg_o.hold_us),
    .last_o       (seg_o.last)
  );

  // The bus is only ever written.
  assign seg_o.read_write = 1'b0;

endmodule

### test/tb_top.sv
// Self-checking testbench for the LCD nibble write sequencer: predicts pin segments and checks them.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lnws_pkg::*;

  // Expected pin state of one segment.
  typedef struct packed {
    logic        reg_select;
    logic        read_write;
    logic        enable;
    logic [3:0]  nibble;
    logic [13:0] hold_us;
    logic        last;
  } pin_seg_t;

  // One pending LCD request.
  typedef struct {
    op_e        op;
    logic [7:0] value;
  } lcd_req_t;

  // Command bytes that follow the power-up nibbles.
  localparam logic [7:0] POWER_UP_CMDS [4] = '{8'h28, 8'h0F, 8'h01, 8'h06};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lnws_req_if req_if ();
  lnws_seg_if seg_if ();
  lnws_cfg_if cfg_if ();

  lcd_nibble_write_sequencer_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .seg_o  (seg_if),
    .cfg_i  (cfg_if)
  );

  cfg_t        timing_model;
  lcd_req_t    req_pending[$];
  pin_seg_t    seg_expect[$];
  int unsigned issued_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned seg_cnt = 0;
  int unsigned setting_cnt = 1;
  int unsigned err_cnt = 0;
  int unsigned req_gap = 0;
  int unsigned seg_stall = 0;
  logic        quiet = 1'b0;

  // Clock generation.
  always begin
    #2 clk_i = ~clk_i;
  end

  // Append one expected segment.
  function automatic void push_seg(logic rs, logic en, logic [3:0] nib, logic [13:0] hold,
                                   logic fin);
    pin_seg_t s;
    s.reg_select = rs;
    s.read_write = 1'b0;
    s.enable     = en;
    s.nibble     = nib;
    s.hold_us    = hold;
    s.last       = fin;
    seg_expect.push_back(s);
  endfunction

  // A byte goes out high nibble first, each nibble strobed once.
  function automatic void push_byte(logic rs, logic [7:0] b, logic fin);
    logic [13:0] pw;
    pw = 14'(timing_model.pulse);
    push_seg(rs, 1'b0, b[7:4], 14'(timing_model.setup) + pw, 1'b0);
    push_seg(rs, 1'b1, b[7:4], pw, 1'b0);
    push_seg(rs, 1'b0, b[3:0], pw, 1'b0);
    push_seg(rs, 1'b1, b[3:0], pw, 1'b0);
    push_seg(rs, 1'b0, b[3:0], 14'(timing_model.settle), fin);
  endfunction

  // Work out the full segment run caused by one request.
  function automatic void predict_request(op_e op, logic [7:0] value);
    logic [13:0] pw;
    pw = 14'(timing_model.pulse);
    case (op)
      OP_INIT: begin
        push_seg(1'b0, 1'b0, 4'd0, INIT_WAIT_US, 1'b0);
        push_seg(1'b0, 1'b0, 4'd3, pw, 1'b0);
        push_seg(1'b0, 1'b1, 4'd3, pw, 1'b0);
        push_seg(1'b0, 1'b0, 4'd3, SECOND_WAIT_US, 1'b0);
        push_seg(1'b0, 1'b1, 4'd3, pw, 1'b0);
        push_seg(1'b0, 1'b0, 4'd3, SHORT_WAIT_US, 1'b0);
        push_seg(1'b0, 1'b1, 4'd3, pw, 1'b0);
        push_seg(1'b0, 1'b0, 4'd3, SHORT_WAIT_US, 1'b0);
        push_seg(1'b0, 1'b0, 4'd2, pw, 1'b0);
        push_seg(1'b0, 1'b1, 4'd2, pw, 1'b0);
        push_seg(1'b0, 1'b0, 4'd2, pw, 1'b0);
        for (int i = 0; i < 4; i++) begin
          push_byte(1'b0, POWER_UP_CMDS[i], i == 3);
        end
      end
      OP_CMD:  push_byte(1'b0, value, 1'b1);
      OP_CHAR: push_byte(1'b1, value, 1'b1);
      default: push_byte(1'b0, value + POS_BASE, 1'b1);
    endcase
  endfunction

  // Request driver: feeds the pending queue, with short random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.op    <= OP_INIT;
      req_if.value <= 8'd0;
      req_gap      <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_request(op_e'(req_if.op), req_if.value);
        taken_cnt <= taken_cnt + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_gap > 0) begin
          req_if.valid <= 1'b0;
          req_gap      <= req_gap - 1;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
          req_if.valid <= 1'b0;
          req_gap      <= $urandom_range(0, 2);
        end else if (req_pending.size() != 0) begin
          lcd_req_t r;
          r = req_pending.pop_front();
          req_if.valid <= 1'b1;
          req_if.op    <= r.op;
          req_if.value <= r.value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Segment monitor: random stalls, and every transaction checked against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_if.ready <= 1'b0;
      seg_stall    <= 0;
    end else begin
      if (seg_if.valid && seg_if.ready) begin
        if (seg_expect.size() == 0) begin
          $error("Unexpected segment: nibble %0h, hold_us %0d", seg_if.nibble, seg_if.hold_us);
          err_cnt++;
        end else begin
          pin_seg_t e;
          e = seg_expect.pop_front();
          seg_cnt <= seg_cnt + 1;
          if (seg_if.reg_select !== e.reg_select) begin
            $error("reg_select: expected %0d, got %0d", e.reg_select, seg_if.reg_select);
            err_cnt++;
          end
          if (seg_if.read_write !== e.read_write) begin
            $error("read_write: expected %0d, got %0d", e.read_write, seg_if.read_write);
            err_cnt++;
          end
          if (seg_if.enable !== e.enable) begin
            $error("enable: expected %0d, got %0d", e.enable, seg_if.enable);
            err_cnt++;
          end
          if (seg_if.nibble !== e.nibble) begin
            $error("nibble: expected %0h, got %0h", e.nibble, seg_if.nibble);
            err_cnt++;
          end
          if (seg_if.hold_us !== e.hold_us) begin
            $error("hold_us: expected %0d, got %0d", e.hold_us, seg_if.hold_us);
            err_cnt++;
          end
          if (seg_if.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, seg_if.last);
            err_cnt++;
          end
        end
      end
      if (seg_stall > 0) begin
        seg_if.ready <= 1'b0;
        seg_stall    <= seg_stall - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        seg_if.ready <= 1'b0;
        seg_stall    <= $urandom_range(0, 2);
      end else begin
        seg_if.ready <= 1'b1;
      end
    end
  end

  // Queue one request for the driver.
  task automatic queue_req(op_e op, logic [7:0] value);
    lcd_req_t r;
    r.op    = op;
    r.value = value;
    req_pending.push_back(r);
    issued_cnt++;
  endtask

  // Wait until every request is taken and every segment has arrived.
  task automatic drain();
    while (taken_cnt != issued_cnt || seg_expect.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // One register write; valid is left high so that writes can follow back to back.
  task automatic write_reg(logic [1:0] index, logic [11:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_if.ready);
    case (index)
      CFG_PULSE:  timing_model.pulse  = data[7:0];
      CFG_SETUP:  timing_model.setup  = data[9:0];
      CFG_SETTLE: timing_model.settle = data[11:0];
      default: ;
    endcase
  endtask

  // Load all three timing registers; upper data bits of the pulse and setup writes carry junk that must be dropped.
  task automatic set_timing(logic [7:0] pulse, logic [9:0] setup, logic [11:0] settle);
    write_reg(CFG_PULSE, {4'($urandom), pulse});
    write_reg(CFG_SETUP, {2'($urandom), setup});
    write_reg(CFG_SETTLE, settle);
    cfg_if.valid <= 1'b0;
    setting_cnt++;
  endtask

  // Pick an extreme or a random value within a range.
  function automatic int unsigned pick(int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) begin
      return 0;
    end else if (r == 1) begin
      return hi;
    end
    return $urandom_range(0, hi);
  endfunction

  // Stimulus: directed cases, then random phases under changing timing.
  initial begin
    op_e op;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_PULSE;
    cfg_if.data  <= 12'd0;
    timing_model.pulse  = PULSE_RST;
    timing_model.setup  = SETUP_RST;
    timing_model.settle = SETTLE_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timing: every operation and the value extremes, position wrap included.
    queue_req(OP_INIT, 8'h00);
    queue_req(OP_CMD, 8'h00);
    queue_req(OP_CMD, 8'hFF);
    queue_req(OP_CHAR, 8'h00);
    queue_req(OP_CHAR, 8'hFF);
    queue_req(OP_CHAR, 8'hA5);
    queue_req(OP_POS, 8'h00);
    queue_req(OP_POS, 8'h7F);
    queue_req(OP_POS, 8'h80);
    queue_req(OP_POS, 8'hFF);
    drain();

    // Zero pulse width and zero waits; a write to the unused index must change nothing.
    write_reg(CFG_PULSE, 12'hF00);
    write_reg(CFG_SETUP, 12'hC00);
    write_reg(CFG_SETTLE, 12'h000);
    write_reg(2'd3, 12'hFFF);
    cfg_if.valid <= 1'b0;
    setting_cnt++;
    queue_req(OP_INIT, 8'h00);
    queue_req(OP_CMD, 8'h3C);
    queue_req(OP_CHAR, 8'hC3);
    drain();

    // Largest values everywhere.
    write_reg(CFG_PULSE, 12'hFFF);
    write_reg(CFG_SETUP, 12'hFFF);
    write_reg(CFG_SETTLE, 12'hFFF);
    cfg_if.valid <= 1'b0;
    setting_cnt++;
    queue_req(OP_INIT, 8'h00);
    queue_req(OP_POS, 8'h01);
    queue_req(OP_CHAR, 8'h5A);
    drain();

    // Random phases; the last one runs without any idling.
    for (int ph = 0; ph < 4; ph++) begin
      quiet = (ph == 3);
      set_timing(8'(pick(255)), 10'(pick(1023)), 12'(pick(4095)));
      repeat (24) begin
        op = ($urandom_range(0, 11) == 0) ? OP_INIT : op_e'($urandom_range(1, 3));
        queue_req(op, 8'($urandom));
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("Checked %0d requests and %0d pin segments under %0d timing settings.",
             taken_cnt, seg_cnt, setting_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #2000000;
    $display("Timeout: %0d segments still expected", seg_expect.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
rtl/core/lnws_pkg.sv
rtl/core/lnws_intf.sv
rtl/core/lnws_cfg_regs.sv
rtl/core/lnws_useq.sv
rtl/core/lnws_seg_dp.sv
rtl/core/lcd_nibble_write_sequencer_core.sv
test/tb_top.sv
